### design/tfe_pkg.sv
// ----------------------------------------------------------------------------
// tfe_pkg
// shared types, codes and helpers for the tag frame extractor
// ----------------------------------------------------------------------------
package tfe_pkg;

  // walk phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TAG  = 2'd1;
  localparam logic [1:0] PH_FRM  = 2'd2;
  localparam logic [1:0] PH_PAY  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // configuration register indexes
  localparam int         CFG_IDX_W  = 1;
  localparam logic [0:0] CFG_MODE   = 1'd0;
  localparam logic [0:0] CFG_WANTED = 1'd1;

  localparam logic [3:0]  HDR_LEN     = 4'd10;
  localparam logic [3:0]  SIZE_FIRST  = 4'd6;
  localparam logic [3:0]  ID_BYTES    = 4'd4;
  localparam logic [3:0]  SIZE_END    = 4'd8;
  localparam logic [31:0] ID_APIC     = 32'h4150_4943;
  localparam logic [7:0]  ID_CHAR_LO  = 8'd65;
  localparam logic [7:0]  ID_CHAR_HI  = 8'd91;
  localparam logic [7:0]  PRINT_LO    = 8'd32;
  localparam logic [7:0]  PRINT_HI    = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tag_start;
  } tfe_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame_id;
    logic [7:0]  text;
    logic        last;
  } tfe_out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  pos;
    logic [31:0] tag_size;
    logic [31:0] frame_name;
    logic [31:0] frame_length;
    logic [31:0] remaining;
    logic        reporting;
  } tfe_state_t;

  // results caused by one byte, in order from kinds[0]
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][1:0] kinds;
    logic [31:0]     frame_id;
    logic [7:0]      text;
  } tfe_step_t;

  // 7-bit-per-byte size accumulation, bit 7 kept
  function automatic logic [31:0] size_shift(input logic [31:0] acc, input logic [7:0] b);
    size_shift = {acc[24:0], 7'b0} + {24'b0, b};
  endfunction

endpackage

### design/tfe_parse.sv
// ----------------------------------------------------------------------------
// tfe_parse
// next-state and result logic for one byte of the tag walk
// ----------------------------------------------------------------------------
module tfe_parse #(
  parameter int COUNT_WIDTH = 32,
  parameter int CNT_W       = 34
) (
  input  tfe_pkg::tfe_in_t    item,
  input  tfe_pkg::tfe_state_t st,
  input  logic [CNT_W-1:0]    consumed,
  input  logic                mode,
  input  logic [31:0]         wanted_id,
  output tfe_pkg::tfe_state_t st_nxt,
  output logic [CNT_W-1:0]    consumed_nxt,
  output tfe_pkg::tfe_step_t  step
);
  import tfe_pkg::*;

  localparam logic [CNT_W-1:0] CountMax = {CNT_W{1'b1}} >> (CNT_W - COUNT_WIDTH);

  logic [7:0]       b;
  logic [3:0]       pos_inc;
  logic [31:0]      name_upd;
  logic [31:0]      len_upd;
  logic [CNT_W-1:0] add;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] cons_add;
  logic [CNT_W-1:0] tag_ext;
  logic             rep_new;
  logic             stop;
  logic [31:0]      rem_dec;
  logic             f_first;
  logic [1:0]       k_first;
  logic             f_end;
  logic             f_done;
  logic [2:0]       flags;
  logic [2:0][1:0]  cand;
  logic [1:0]       n;

  always_comb begin
    b        = item.data_byte;
    pos_inc  = st.pos + 4'd1;
    name_upd = (st.pos < ID_BYTES) ? {st.frame_name[23:0], b} : st.frame_name;
    len_upd  = (st.pos >= ID_BYTES && st.pos < SIZE_END) ?
               size_shift(st.frame_length, b) : st.frame_length;
    add      = CNT_W'(len_upd) + CNT_W'(HDR_LEN);
    sum      = consumed + add;
    // headroom check before the add, so a full-width count never wraps
    cons_add = ((add <= CountMax) && (consumed > CountMax - add)) ? CountMax : sum;
    tag_ext  = CNT_W'(st.tag_size);
    rem_dec  = st.remaining - {31'b0, (st.remaining != 32'd0)};

    if (mode) begin
      rep_new = (name_upd == wanted_id);
      stop    = 1'b0;
    end else if (name_upd == ID_APIC) begin
      rep_new = 1'b0;
      stop    = 1'b0;
    end else begin
      rep_new = (name_upd[31:24] >= ID_CHAR_LO) && (name_upd[31:24] <= ID_CHAR_HI);
      stop    = !rep_new;
    end

    st_nxt       = st;
    consumed_nxt = consumed;
    f_first      = 1'b0;
    k_first      = KIND_START;
    f_end        = 1'b0;
    f_done       = 1'b0;
    step.frame_id = st.frame_name;
    step.text     = b;

    if (item.tag_start) begin
      st_nxt       = '0;
      st_nxt.phase = PH_TAG;
      st_nxt.pos   = 4'd1;
      consumed_nxt = '0;
    end else begin
      case (st.phase)
        PH_TAG: begin
          if (st.pos >= SIZE_FIRST) st_nxt.tag_size = size_shift(st.tag_size, b);
          st_nxt.pos = pos_inc;
          if (pos_inc >= HDR_LEN) begin
            st_nxt.phase        = PH_FRM;
            st_nxt.pos          = 4'd0;
            st_nxt.frame_name   = '0;
            st_nxt.frame_length = '0;
          end
        end
        PH_FRM: begin
          st_nxt.frame_name   = name_upd;
          st_nxt.frame_length = len_upd;
          st_nxt.pos          = pos_inc;
          step.frame_id       = name_upd;
          if (pos_inc >= HDR_LEN) begin
            st_nxt.pos   = 4'd0;
            consumed_nxt = cons_add;
            if (stop) begin
              f_done           = 1'b1;
              st_nxt.phase     = PH_IDLE;
              st_nxt.reporting = 1'b0;
            end else begin
              st_nxt.reporting = rep_new;
              f_first          = rep_new;
              k_first          = KIND_START;
              st_nxt.remaining = len_upd;
              if (len_upd == 32'd0) begin
                // empty frame closes on its last header byte
                f_end            = rep_new;
                st_nxt.reporting = 1'b0;
                if (cons_add > tag_ext) begin
                  f_done       = 1'b1;
                  st_nxt.phase = PH_IDLE;
                end else begin
                  st_nxt.phase        = PH_FRM;
                  st_nxt.frame_name   = '0;
                  st_nxt.frame_length = '0;
                end
              end else begin
                st_nxt.phase = PH_PAY;
              end
            end
          end
        end
        PH_PAY: begin
          st_nxt.remaining = rem_dec;
          f_first = st.reporting && (b >= PRINT_LO) && (b <= PRINT_HI);
          k_first = KIND_TEXT;
          if (rem_dec == 32'd0) begin
            f_end            = st.reporting;
            st_nxt.reporting = 1'b0;
            if (consumed > tag_ext) begin
              f_done       = 1'b1;
              st_nxt.phase = PH_IDLE;
            end else begin
              st_nxt.phase        = PH_FRM;
              st_nxt.pos          = 4'd0;
              st_nxt.frame_name   = '0;
              st_nxt.frame_length = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // pack the raised results in order
    flags = {f_done, f_end, f_first};
    cand  = {KIND_DONE, KIND_END, k_first};
    n     = 2'd0;
    step.kinds = '0;
    for (int i = 0; i < 3; i++) begin
      if (flags[i]) begin
        step.kinds[n] = cand[i];
        n = n + 2'd1;
      end
    end
    step.cnt = n;
  end

endmodule

### design/tfe_rbuf.sv
// ----------------------------------------------------------------------------
// tfe_rbuf
// result register: holds the results of one byte and hands them out one beat
// at a time
// ----------------------------------------------------------------------------
module tfe_rbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  tfe_pkg::tfe_step_t step,
  input  logic               out_stall,
  output logic               out_valid,
  output tfe_pkg::tfe_out_t  out_data,
  output logic               free
);
  import tfe_pkg::*;

  logic [1:0]      rc_r;
  logic [1:0]      rc_nxt;
  logic [2:0][1:0] kinds_r;
  logic [31:0]     id_r;
  logic [7:0]      text_r;
  logic            take;

  assign out_valid = (rc_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign free      = (rc_r == 2'd0) || ((rc_r == 2'd1) && take);

  always_comb begin
    rc_nxt = rc_r;
    if (load)      rc_nxt = step.cnt;
    else if (take) rc_nxt = rc_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= 2'd0;
    end else begin
      rc_r <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kinds_r <= step.kinds;
      id_r    <= step.frame_id;
      text_r  <= step.text;
    end else if (take) begin
      kinds_r <= {2'b00, kinds_r[2], kinds_r[1]};
    end
  end

  always_comb begin
    out_data.kind     = kinds_r[0];
    out_data.frame_id = id_r;
    out_data.text     = (kinds_r[0] == KIND_TEXT) ? text_r : 8'd0;
    out_data.last     = (rc_r == 2'd1);
  end

endmodule

### design/tag_frame_extractor.sv
// ----------------------------------------------------------------------------
// tag_frame_extractor
// walks a metadata tag one byte per beat and reports the printable text of
// its frames as start / text / end / finished results
// ----------------------------------------------------------------------------
// path: a byte is registered in the input register on acceptance, parsed from
//   there, and its results are registered in the result register before out_valid
// throughput: one byte per cycle while each byte yields at most one result and
//   out_stall is low; a byte that yields k results (k up to 3) holds the input
//   until all but the last of them have left the result register
// reset: synchronous active-low rst_n clears the walk, the counters, the
//   configuration registers and all pending results
// ----------------------------------------------------------------------------
module tag_frame_extractor #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tfe_pkg::tfe_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tfe_pkg::tfe_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import tfe_pkg::*;

  // consumed count must hold one unsaturated frame add past a 32-bit tag size
  localparam int CNT_W = (COUNT_WIDTH > 34) ? COUNT_WIDTH : 34;

  // input register
  logic             in_valid_r;
  tfe_in_t          in_r;

  // walk state
  tfe_state_t       st_r;
  tfe_state_t       st_nxt;
  logic [CNT_W-1:0] consumed_r;
  logic [CNT_W-1:0] consumed_nxt;

  // configuration
  logic             mode_r;
  logic [31:0]      wanted_r;

  tfe_step_t        step;
  logic             buf_free;
  logic             fire;

  // a byte is parsed once the result register can take all its results
  assign fire      = in_valid_r && buf_free;
  assign in_stall  = in_valid_r && !buf_free;
  assign cfg_ready = 1'b1;

  // input register refills whenever its byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
  end

  // configuration writes: the user must issue them only while the walk is quiet; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      wanted_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_WANTED: wanted_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tfe_parse #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .CNT_W       (CNT_W)
  ) u_parse (
    .item         (in_r),
    .st           (st_r),
    .consumed     (consumed_r),
    .mode         (mode_r),
    .wanted_id    (wanted_r),
    .st_nxt       (st_nxt),
    .consumed_nxt (consumed_nxt),
    .step         (step)
  );

  // walk state advances once per parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      consumed_r <= '0;
    end else if (fire) begin
      st_r       <= st_nxt;
      consumed_r <= consumed_nxt;
    end
  end

  tfe_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .step      (step),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (buf_free)
  );

  // a tag restart never produces a result
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_r.tag_start |=> !out_valid)
    else $error("result after tag restart");

  // header byte counter stays within the header length
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos <= HDR_LEN)
    else $error("header position out of range");

  // payload phase always has bytes left to take
  a_pay_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_PAY |-> st_r.remaining != 32'd0)
    else $error("payload phase with nothing remaining");

  // walk-finished is always the final result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DONE |-> out_data.last)
    else $error("finish result not marked last");

endmodule
